>>> rtl/tgf_pkg.sv
// ----------------------------------------------------------------------------
// tgf_pkg
// shared types and request codes of the tile grid flood fill block
// ----------------------------------------------------------------------------
`default_nettype none

package tgf_pkg;

    typedef logic [7:0] t_tile;
    typedef logic [2:0] t_req;
    typedef logic [4:0] t_coord;
    typedef logic [6:0] t_count;

    localparam t_req REQ_PAINT = 3'd0;
    localparam t_req REQ_READ  = 3'd1;
    localparam t_req REQ_FILL  = 3'd2;
    localparam t_req REQ_UNDO  = 3'd3;
    localparam t_req REQ_REDO  = 3'd4;

endpackage

`default_nettype wire

>>> rtl/tgf_ram.sv
// ----------------------------------------------------------------------------
// tgf_ram
// single port synchronous ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module tgf_ram #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        o_rdata <= mem[i_addr];
    end

endmodule

`default_nettype wire

>>> rtl/tile_grid_flood_fill_with_undo.sv
// ----------------------------------------------------------------------------
// tile_grid_flood_fill_with_undo
// tile grid editor: paint, read, four-connected flood fill, undo and redo
// ----------------------------------------------------------------------------
// a request transfers at a rising edge with start high and busy low.
// one result follows per request, on the o_ ports for one cycle with
// o_valid high; the receiver cannot stall it.
// grid, history ring and fill stack each live in a single port ram.
// read and no-op requests: read the cell, then report; plain paint: read,
// then write the cell. paint at a stroke start first copies the whole grid
// into a history slot (snapshot), each cell read through the grid ram port.
// fill: snapshot, then seed the stack, pop entries, paint each popped cell
// that matches the target and push its in-grid neighbours while there is room.
// undo / redo: read, then write back swapped cells.
// after reset the grid ram is cleared, one cell a cycle, with busy high;
// history and counters start empty.
// ----------------------------------------------------------------------------
`default_nettype none

module tile_grid_flood_fill_with_undo #(
    parameter int ROWS          = 20,
    parameter int COLS          = 20,
    parameter int HISTORY_DEPTH = 64,
    parameter int STACK_DEPTH   = 2048
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire tgf_pkg::t_req   i_req_type,
    input  wire tgf_pkg::t_coord i_row,
    input  wire tgf_pkg::t_coord i_col,
    input  wire tgf_pkg::t_tile  i_code,
    input  wire logic            i_stroke_start,
    output logic                 o_valid,
    output tgf_pkg::t_tile       o_read_value,
    output logic                 o_changed,
    output tgf_pkg::t_count      o_undo_count,
    output tgf_pkg::t_count      o_redo_count
);

    import tgf_pkg::*;

    localparam int NC  = ROWS * COLS;
    localparam int GW  = (NC > 1) ? $clog2(NC) : 1;
    localparam int HD  = HISTORY_DEPTH * NC;
    localparam int HAW = (HD > 1) ? $clog2(HD) : 1;
    localparam int SW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int TW  = $clog2(STACK_DEPTH + 1);

    localparam logic [3:0] S_CLR     = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_RD      = 4'd2;
    localparam logic [3:0] S_EVAL    = 4'd3;
    localparam logic [3:0] S_SNAP_RD = 4'd4;
    localparam logic [3:0] S_SNAP_WR = 4'd5;
    localparam logic [3:0] S_PAINT   = 4'd6;
    localparam logic [3:0] S_SEED    = 4'd7;
    localparam logic [3:0] S_POP     = 4'd8;
    localparam logic [3:0] S_FCHK    = 4'd9;
    localparam logic [3:0] S_FTEST   = 4'd10;
    localparam logic [3:0] S_PUSH    = 4'd11;
    localparam logic [3:0] S_SW_RD   = 4'd12;
    localparam logic [3:0] S_SW_WR   = 4'd13;
    localparam logic [3:0] S_DONE    = 4'd14;

    logic [3:0]    r_state;
    t_req          r_req;
    logic [5:0]    r_row, r_col;
    t_tile         r_code, r_target, r_rv;
    logic          r_stroke, r_inside, r_chg;
    logic [GW-1:0] r_idx, r_cnt;
    logic [TW-1:0] r_top;
    logic [SW-1:0] r_oldest, r_slot;
    t_count        r_undo, r_redo;
    logic [5:0]    r_prow, r_pcol;
    logic [1:0]    r_nb;

    logic           g_we, h_we, s_we;
    logic [GW-1:0]  g_addr;
    logic [HAW-1:0] h_addr;
    logic [SAW-1:0] s_addr;
    t_tile          g_wd, h_wd, g_rd, h_rd;
    logic [11:0]    s_wd, s_rd;

    tgf_ram #(.DEPTH(NC), .WIDTH(8)) u_grid (
        .i_clk(i_clk), .i_we(g_we), .i_addr(g_addr), .i_wdata(g_wd), .o_rdata(g_rd)
    );
    tgf_ram #(.DEPTH(HD), .WIDTH(8)) u_hist (
        .i_clk(i_clk), .i_we(h_we), .i_addr(h_addr), .i_wdata(h_wd), .o_rdata(h_rd)
    );
    tgf_ram #(.DEPTH(STACK_DEPTH), .WIDTH(12)) u_stack (
        .i_clk(i_clk), .i_we(s_we), .i_addr(s_addr), .i_wdata(s_wd), .o_rdata(s_rd)
    );

    logic          in_inside;
    logic [GW-1:0] in_idx, pop_idx, last_cell;
    logic [7:0]    snap_sum, undo_sum;
    logic [SW-1:0] snap_slot, undo_slot;
    logic          nb_ok;
    logic [11:0]   nb_cell;

    assign last_cell = GW'(NC - 1);
    assign in_inside = (7'(i_row) < 7'(ROWS)) && (7'(i_col) < 7'(COLS));
    assign in_idx    = in_inside ? GW'(int'(i_row) * COLS + int'(i_col)) : '0;
    assign pop_idx   = GW'(int'(r_prow) * COLS + int'(r_pcol));

    // ring slot of the next snapshot and of the newest undo entry
    assign snap_sum  = 8'(r_oldest) + 8'(r_undo);
    assign snap_slot = (snap_sum >= 8'(HISTORY_DEPTH)) ?
                       SW'(snap_sum - 8'(HISTORY_DEPTH)) : SW'(snap_sum);
    assign undo_sum  = 8'(r_oldest) + 8'(r_undo) - 8'd1;
    assign undo_slot = (undo_sum >= 8'(HISTORY_DEPTH)) ?
                       SW'(undo_sum - 8'(HISTORY_DEPTH)) : SW'(undo_sum);

    always_comb begin
        nb_ok   = 1'b0;
        nb_cell = {r_prow, r_pcol};
        case (r_nb)
            2'd0: begin
                nb_ok   = r_prow != 6'd0;
                nb_cell = {r_prow - 6'd1, r_pcol};
            end
            2'd1: begin
                nb_ok   = (7'(r_prow) + 7'd1) < 7'(ROWS);
                nb_cell = {r_prow + 6'd1, r_pcol};
            end
            2'd2: begin
                nb_ok   = r_pcol != 6'd0;
                nb_cell = {r_prow, r_pcol - 6'd1};
            end
            default: begin
                nb_ok   = (7'(r_pcol) + 7'd1) < 7'(COLS);
                nb_cell = {r_prow, r_pcol + 6'd1};
            end
        endcase
    end

    // memory port control
    always_comb begin
        g_we   = 1'b0;
        g_addr = r_idx;
        g_wd   = r_code;
        h_we   = 1'b0;
        h_addr = HAW'(int'(r_slot) * NC + int'(r_cnt));
        h_wd   = g_rd;
        s_we   = 1'b0;
        s_addr = r_top[SAW-1:0];
        s_wd   = nb_cell;
        unique case (r_state)
            S_CLR: begin
                g_we   = 1'b1;
                g_addr = r_cnt;
                g_wd   = '0;
            end
            S_IDLE:    g_addr = in_idx;
            S_SNAP_RD: g_addr = r_cnt;
            S_SNAP_WR: h_we   = 1'b1;
            S_PAINT:   g_we   = 1'b1;
            S_SEED: begin
                s_we   = 1'b1;
                s_addr = '0;
                s_wd   = {r_row, r_col};
            end
            S_POP:     s_addr = SAW'(r_top - TW'(1));
            S_FCHK:    g_addr = GW'(int'(s_rd[11:6]) * COLS + int'(s_rd[5:0]));
            S_FTEST: begin
                g_addr = pop_idx;
                g_we   = g_rd == r_target;
            end
            S_PUSH:    s_we   = nb_ok && (r_top < TW'(STACK_DEPTH));
            S_SW_RD:   g_addr = r_cnt;
            S_SW_WR: begin
                g_addr = r_cnt;
                g_we   = 1'b1;
                g_wd   = h_rd;
                h_we   = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_cnt    <= '0;
            r_oldest <= '0;
            r_undo   <= '0;
            r_redo   <= '0;
            r_top    <= '0;
        end else begin
            unique case (r_state)
                S_CLR: begin
                    r_cnt <= r_cnt + GW'(1);
                    if (r_cnt == last_cell) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_req    <= i_req_type;
                        r_row    <= {1'b0, i_row};
                        r_col    <= {1'b0, i_col};
                        r_code   <= i_code;
                        r_stroke <= i_stroke_start;
                        r_inside <= in_inside;
                        r_idx    <= in_idx;
                        r_state  <= S_RD;
                    end
                end
                S_RD: r_state <= S_EVAL;
                S_EVAL: begin
                    r_chg   <= 1'b0;
                    r_rv    <= r_inside ? g_rd : 8'd0;
                    r_cnt   <= '0;
                    r_state <= S_DONE;
                    case (r_req)
                        REQ_PAINT: begin
                            if (r_inside && g_rd != r_code) begin
                                r_slot  <= snap_slot;
                                r_state <= r_stroke ? S_SNAP_RD : S_PAINT;
                            end
                        end
                        REQ_FILL: begin
                            if (r_inside && g_rd != r_code) begin
                                r_target <= g_rd;
                                r_slot   <= snap_slot;
                                r_state  <= S_SNAP_RD;
                            end
                        end
                        REQ_UNDO: begin
                            if (r_undo != '0) begin
                                r_slot  <= undo_slot;
                                r_rv    <= 8'd0;
                                r_state <= S_SW_RD;
                            end
                        end
                        REQ_REDO: begin
                            if (r_redo != '0) begin
                                r_slot  <= snap_slot;
                                r_rv    <= 8'd0;
                                r_state <= S_SW_RD;
                            end
                        end
                        default: ;
                    endcase
                end
                S_SNAP_RD: r_state <= S_SNAP_WR;
                S_SNAP_WR: begin
                    r_cnt   <= r_cnt + GW'(1);
                    r_state <= S_SNAP_RD;
                    if (r_cnt == last_cell) begin
                        if (r_undo >= 7'(HISTORY_DEPTH)) begin
                            r_oldest <= (r_oldest == SW'(HISTORY_DEPTH - 1)) ?
                                        '0 : r_oldest + SW'(1);
                        end else begin
                            r_undo <= r_undo + 7'd1;
                        end
                        r_redo  <= '0;
                        r_state <= (r_req == REQ_FILL) ? S_SEED : S_PAINT;
                    end
                end
                S_PAINT: begin
                    r_chg   <= 1'b1;
                    r_rv    <= r_code;
                    r_state <= S_DONE;
                end
                S_SEED: begin
                    r_top   <= TW'(1);
                    r_state <= S_POP;
                end
                S_POP: begin
                    if (r_top == '0) begin
                        r_chg   <= 1'b1;
                        r_rv    <= r_code;
                        r_state <= S_DONE;
                    end else begin
                        r_top   <= r_top - TW'(1);
                        r_state <= S_FCHK;
                    end
                end
                S_FCHK: begin
                    r_prow  <= s_rd[11:6];
                    r_pcol  <= s_rd[5:0];
                    r_state <= S_FTEST;
                end
                S_FTEST: begin
                    r_nb    <= 2'd0;
                    r_state <= (g_rd == r_target) ? S_PUSH : S_POP;
                end
                S_PUSH: begin
                    if (nb_ok && (r_top < TW'(STACK_DEPTH))) begin
                        r_top <= r_top + TW'(1);
                    end
                    r_nb <= r_nb + 2'd1;
                    if (r_nb == 2'd3) begin
                        r_state <= S_POP;
                    end
                end
                S_SW_RD: r_state <= S_SW_WR;
                S_SW_WR: begin
                    if (h_rd != g_rd) begin
                        r_chg <= 1'b1;
                    end
                    if (r_inside && r_cnt == r_idx) begin
                        r_rv <= h_rd;
                    end
                    r_cnt   <= r_cnt + GW'(1);
                    r_state <= S_SW_RD;
                    if (r_cnt == last_cell) begin
                        if (r_req == REQ_UNDO) begin
                            r_undo <= r_undo - 7'd1;
                            r_redo <= r_redo + 7'd1;
                        end else begin
                            r_undo <= r_undo + 7'd1;
                            r_redo <= r_redo - 7'd1;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DONE: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy         = r_state != S_IDLE;
    assign o_valid      = r_state == S_DONE;
    assign o_read_value = r_rv;
    assign o_changed    = r_chg;
    assign o_undo_count = r_undo;
    assign o_redo_count = r_redo;

endmodule

`default_nettype wire
